FILE: sv/joint_trajectory_interpolator_core_macros.svh
// Assertion macros shared by the interpolator core
`ifndef JOINT_TRAJECTORY_INTERPOLATOR_CORE_MACROS_SVH
`define JOINT_TRAJECTORY_INTERPOLATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: sv/jti_pkg.sv
package jti_pkg;

  localparam int POS_W         = 20;
  localparam int POS_FRAC_BITS = 16;
  localparam int RATE_W        = 10;
  localparam int DUR_W         = 20;
  localparam int CNT_W         = 20;
  localparam int PPT_W         = RATE_W + DUR_W;
  localparam int FRAC_W        = 31;
  localparam int S_W           = 32;
  localparam int H_W           = 33;
  localparam int MUL_W         = 34;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int DIV_STEPS     = S_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
  // numerator is k * 2^(FRAC_W+10); the quotient fits S_W bits once k < step total
  localparam int DIV_PRE_SHIFT = FRAC_W + 10 - S_W;
  localparam int TOTAL_SHIFT   = 10;
  localparam int WRAP_W        = POS_W + 2;
  localparam int CFG_IDX_W     = 3;

  localparam longint PI_Q32 = 64'sd13493037705;
  localparam longint PI_Q   = (PI_Q32 + (64'sd1 <<< (31 - POS_FRAC_BITS)))
                              >>> (32 - POS_FRAC_BITS);
  localparam logic signed [WRAP_W-1:0] PI_W     = WRAP_W'(PI_Q);
  localparam logic signed [WRAP_W-1:0] TWO_PI_W = WRAP_W'(2 * PI_Q);

  localparam logic signed [POS_W-1:0] EXT_RESET     = 20'sd108134;
  localparam logic signed [POS_W-1:0] J2_LOW_RESET  = -20'sd154415;
  localparam logic signed [POS_W-1:0] J2_HIGH_RESET = 20'sd147862;
  localparam logic signed [POS_W-1:0] J3_LOW_RESET  = 20'sd0;
  localparam logic signed [POS_W-1:0] J3_HIGH_RESET = 20'sd196608;
  localparam logic [RATE_W-1:0]       RATE_RESET    = 10'd20;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_J2_LOW, REG_J2_HIGH, REG_J3_LOW, REG_J3_HIGH, REG_TICK_RATE
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STAT_OK, STAT_BAD_DUR, STAT_J2_RANGE, STAT_J3_RANGE
  } status_t;

  typedef struct packed {
    logic                    operation;
    logic signed [POS_W-1:0] target_angle1;
    logic signed [POS_W-1:0] target_angle2;
    logic signed [POS_W-1:0] target_extension;
    logic [DUR_W-1:0]        duration;
    logic                    cubic_mode;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] angle1;
    logic signed [POS_W-1:0] angle2;
    logic signed [POS_W-1:0] extension;
    logic [1:0]              status;
    logic                    moving;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_WRAP, S_SNAP, S_DIV_INIT, S_DIV, S_SHAPE, S_SQ,
    S_SQ_USE, S_CUBE, S_CUBE_USE, S_BL0, S_BL1, S_BL2, S_BL3, S_FINISH
  } ctrl_state_t;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_LATCH, ACT_CHECK, ACT_WRAP, ACT_COMMIT, ACT_SNAP,
    ACT_DIV_INIT, ACT_DIV_STEP, ACT_SHAPE, ACT_SQ_USE, ACT_CUBE_USE,
    ACT_BLEND, ACT_BLEND_LAST, ACT_LOAD_OUT
  } dp_act_t;

  typedef enum logic [1:0] {
    MUL_RATE_DUR, MUL_SS, MUL_S2S, MUL_BLEND
  } mul_sel_t;

  typedef struct packed {
    dp_act_t    act;
    mul_sel_t   mul_sel;
    logic [1:0] joint;
  } dp_cmd_t;

  typedef struct packed {
    logic    is_cmd;
    status_t check;
    logic    active;
    logic    tick_end;
    logic    wrap_done;
    logic    div_last;
    logic    cubic;
    logic    out_free;
  } dp_sts_t;

endpackage

FILE: sv/jti_datapath.sv
module jti_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  jti_pkg::dp_cmd_t                  cmd,
  output jti_pkg::dp_sts_t                  sts,
  input  jti_pkg::in_item_t                 in_data,
  output jti_pkg::out_item_t                out_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              cfg_valid,
  input  logic [jti_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jti_pkg::POS_W-1:0]         cfg_data
);
  import jti_pkg::*;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);
  localparam logic [S_W-1:0]           ONE_S      = S_W'(1) << FRAC_W;

  logic signed [POS_W-1:0] j2_lo, j2_hi, j3_lo, j3_hi;
  logic [RATE_W-1:0]       tick_rate;

  logic signed [POS_W-1:0] cur [3];
  logic signed [POS_W-1:0] start [3];
  logic signed [POS_W-1:0] tgt [3];
  logic [CNT_W-1:0]        idx, total;
  logic [PPT_W-1:0]        ppt;
  logic                    cubic, active;
  status_t                 status_q;

  in_item_t                item;
  logic signed [WRAP_W-1:0] a1;
  logic [PPT_W-1:0]        rem;
  logic [S_W-1:0]          q, s, s2;
  logic [H_W-1:0]          h;
  logic signed [PROD_W-1:0] prod;
  logic [1:0]              joint_q;
  logic [DIV_CNT_W-1:0]    div_cnt;

  status_t                 check;
  logic                    a1_hi, a1_lo;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic [1:0]              jsel;
  logic signed [POS_W:0]   diff;
  logic [PPT_W:0]          trial;
  logic                    trial_ge;
  logic [S_W-1:0]          s_cl, s3;
  logic [S_W+1:0]          h_calc;
  logic signed [PROD_W-1:0] bl_sum;
  logic signed [PROD_W-1:0] bl_shift;
  logic signed [POS_W-1:0] pos_new;
  logic [CNT_W-1:0]        total_new;

  always_comb begin
    if (item.duration == '0) begin
      check = STAT_BAD_DUR;
    end else if (item.target_angle2 > j2_hi || item.target_angle2 < j2_lo) begin
      check = STAT_J2_RANGE;
    end else if (item.target_extension > j3_hi || item.target_extension < j3_lo) begin
      check = STAT_J3_RANGE;
    end else begin
      check = STAT_OK;
    end
  end

  assign a1_hi = a1 > PI_W;
  assign a1_lo = a1 < -PI_W;

  assign jsel = (cmd.joint > 2'd2) ? 2'd0 : cmd.joint;
  assign diff = {tgt[jsel][POS_W-1], tgt[jsel]} - {start[jsel][POS_W-1], start[jsel]};

  always_comb begin
    case (cmd.mul_sel)
      MUL_SS: begin
        mul_a = $signed(MUL_W'(s));
        mul_b = $signed(MUL_W'(s));
      end
      MUL_S2S: begin
        mul_a = $signed(MUL_W'(s2));
        mul_b = $signed(MUL_W'(s));
      end
      MUL_BLEND: begin
        mul_a = MUL_W'(diff);
        mul_b = $signed(MUL_W'(h));
      end
      default: begin
        mul_a = $signed(MUL_W'(tick_rate));
        mul_b = $signed(MUL_W'(item.duration));
      end
    endcase
  end

  assign trial    = {rem, 1'b0};
  assign trial_ge = trial >= {1'b0, ppt};
  assign s_cl     = (q > ONE_S) ? ONE_S : q;
  assign s3       = prod[FRAC_W +: S_W];
  // 3*s2 - 2*s3, never negative since s3 <= s2
  assign h_calc   = ({2'b00, s2} << 1) + {2'b00, s2} - ({2'b00, s3} << 1);
  assign bl_sum   = prod + ROUND_HALF;
  assign bl_shift = bl_sum >>> FRAC_W;
  assign pos_new  = start[joint_q] + bl_shift[POS_W-1:0];
  assign total_new = prod[TOTAL_SHIFT +: CNT_W];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      j2_lo     <= J2_LOW_RESET;
      j2_hi     <= J2_HIGH_RESET;
      j3_lo     <= J3_LOW_RESET;
      j3_hi     <= J3_HIGH_RESET;
      tick_rate <= RATE_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_J2_LOW:    j2_lo     <= cfg_data;
        REG_J2_HIGH:   j2_hi     <= cfg_data;
        REG_J3_LOW:    j3_lo     <= cfg_data;
        REG_J3_HIGH:   j3_hi     <= cfg_data;
        REG_TICK_RATE: tick_rate <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // trajectory state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        cur[i]   <= '0;
        start[i] <= '0;
        tgt[i]   <= '0;
      end
      cur[2]   <= EXT_RESET;
      start[2] <= EXT_RESET;
      tgt[2]   <= EXT_RESET;
      idx      <= '0;
      total    <= '0;
      ppt      <= '0;
      cubic    <= 1'b0;
      active   <= 1'b0;
      status_q <= STAT_OK;
    end else begin
      case (cmd.act)
        ACT_CHECK: begin
          status_q <= (item.operation == OP_COMMAND) ? check : STAT_OK;
        end
        ACT_COMMIT: begin
          tgt[0] <= a1[POS_W-1:0];
          tgt[1] <= item.target_angle2;
          tgt[2] <= item.target_extension;
          for (int i = 0; i < 3; i++) start[i] <= cur[i];
          ppt   <= prod[PPT_W-1:0];
          cubic <= item.cubic_mode;
          if (total_new == '0) begin
            // too short for a single tick: go straight to the target
            cur[0] <= a1[POS_W-1:0];
            cur[1] <= item.target_angle2;
            cur[2] <= item.target_extension;
            active <= 1'b0;
            idx    <= '0;
            total  <= '0;
          end else begin
            active <= 1'b1;
            idx    <= CNT_W'(1);
            total  <= total_new;
          end
        end
        ACT_SNAP: begin
          for (int i = 0; i < 3; i++) cur[i] <= tgt[i];
          active <= 1'b0;
          idx    <= '0;
          total  <= '0;
        end
        ACT_BLEND: begin
          cur[joint_q] <= pos_new;
        end
        ACT_BLEND_LAST: begin
          cur[joint_q] <= pos_new;
          idx          <= idx + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod    <= mul_a * mul_b;
    joint_q <= cmd.joint;
    case (cmd.act)
      ACT_LATCH: begin
        item <= in_data;
        a1   <= WRAP_W'(in_data.target_angle1);
      end
      ACT_WRAP: begin
        if (a1_hi) begin
          a1 <= a1 - TWO_PI_W;
        end else if (a1_lo) begin
          a1 <= a1 + TWO_PI_W;
        end
      end
      ACT_DIV_INIT: begin
        rem     <= PPT_W'({idx, {DIV_PRE_SHIFT{1'b0}}});
        q       <= '0;
        div_cnt <= '0;
      end
      ACT_DIV_STEP: begin
        rem     <= trial_ge ? PPT_W'(trial - {1'b0, ppt}) : trial[PPT_W-1:0];
        q       <= {q[S_W-2:0], trial_ge};
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      ACT_SHAPE: begin
        s <= s_cl;
        h <= H_W'(s_cl);
      end
      ACT_SQ_USE: begin
        s2 <= prod[FRAC_W +: S_W];
      end
      ACT_CUBE_USE: begin
        h <= H_W'(h_calc);
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.act == ACT_LOAD_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act == ACT_LOAD_OUT) begin
      out_data.angle1    <= cur[0];
      out_data.angle2    <= cur[1];
      out_data.extension <= cur[2];
      out_data.status    <= status_q;
      out_data.moving    <= active;
    end
  end

  assign sts.is_cmd    = item.operation == OP_COMMAND;
  assign sts.check     = check;
  assign sts.active    = active;
  assign sts.tick_end  = (idx >= total) || (ppt == '0);
  assign sts.wrap_done = !a1_hi && !a1_lo;
  assign sts.div_last  = div_cnt == DIV_CNT_W'(DIV_STEPS - 1);
  assign sts.cubic     = cubic;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

FILE: sv/jti_ctrl.sv
`include "joint_trajectory_interpolator_core_macros.svh"

module jti_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  jti_pkg::dp_sts_t sts,
  output jti_pkg::dp_cmd_t cmd
);
  import jti_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (sts.is_cmd) begin
          state_next = (sts.check != STAT_OK) ? S_FINISH : S_WRAP;
        end else if (!sts.active) begin
          state_next = S_FINISH;
        end else if (sts.tick_end) begin
          state_next = S_SNAP;
        end else begin
          state_next = S_DIV_INIT;
        end
      end
      S_WRAP:     if (sts.wrap_done) state_next = S_FINISH;
      S_SNAP:     state_next = S_FINISH;
      S_DIV_INIT: state_next = S_DIV;
      S_DIV:      if (sts.div_last) state_next = S_SHAPE;
      S_SHAPE:    state_next = sts.cubic ? S_SQ : S_BL0;
      S_SQ:       state_next = S_SQ_USE;
      S_SQ_USE:   state_next = S_CUBE;
      S_CUBE:     state_next = S_CUBE_USE;
      S_CUBE_USE: state_next = S_BL0;
      S_BL0:      state_next = S_BL1;
      S_BL1:      state_next = S_BL2;
      S_BL2:      state_next = S_BL3;
      S_BL3:      state_next = S_FINISH;
      S_FINISH:   if (sts.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.act     = ACT_NONE;
    cmd.mul_sel = MUL_RATE_DUR;
    cmd.joint   = 2'd0;
    in_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.act = ACT_LATCH;
      end
      S_DECODE:   cmd.act = ACT_CHECK;
      S_WRAP:     cmd.act = sts.wrap_done ? ACT_COMMIT : ACT_WRAP;
      S_SNAP:     cmd.act = ACT_SNAP;
      S_DIV_INIT: cmd.act = ACT_DIV_INIT;
      S_DIV:      cmd.act = ACT_DIV_STEP;
      S_SHAPE:    cmd.act = ACT_SHAPE;
      S_SQ:       cmd.mul_sel = MUL_SS;
      S_SQ_USE:   cmd.act = ACT_SQ_USE;
      S_CUBE:     cmd.mul_sel = MUL_S2S;
      S_CUBE_USE: cmd.act = ACT_CUBE_USE;
      S_BL0: begin
        cmd.mul_sel = MUL_BLEND;
        cmd.joint   = 2'd0;
      end
      // multiply the next joint while the previous product is written back
      S_BL1: begin
        cmd.mul_sel = MUL_BLEND;
        cmd.joint   = 2'd1;
        cmd.act     = ACT_BLEND;
      end
      S_BL2: begin
        cmd.mul_sel = MUL_BLEND;
        cmd.joint   = 2'd2;
        cmd.act     = ACT_BLEND;
      end
      S_BL3:      cmd.act = ACT_BLEND_LAST;
      S_FINISH:   if (sts.out_free) cmd.act = ACT_LOAD_OUT;
      default: ;
    endcase
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_AT(a_load_needs_slot, clk, rst, (cmd.act == ACT_LOAD_OUT) |-> sts.out_free)
  `ASSERT_NEXT(a_div_exit, clk, rst, (state == S_DIV) && sts.div_last, state == S_SHAPE)

endmodule

FILE: sv/joint_trajectory_interpolator_core.sv
// Channel   Handshake              Word
// in        in_valid / in_ready    in_data  (tick or motion command)
// out       out_valid / out_ready  out_data (setpoints, status, moving)
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// One item at a time. A tick while moving forms its progress fraction with the
// 32-step restoring divider, in cubic mode shapes it, then blends each joint.
// The tick that ends a motion snaps to the target. A valid command wraps angle 1
// into range one wrap step at a time; rejected commands and idle ticks skip this.
// The next item is taken while the previous word waits in the output register.
// Reset is synchronous; positions come up at 0, 0 and 1.65 m.
module joint_trajectory_interpolator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  jti_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output jti_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jti_pkg::POS_W-1:0]     cfg_data
);
  import jti_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  jti_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jti_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jti_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [POS_W-1:0] cfg_data;

  joint_trajectory_interpolator_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predicted block state
  logic signed [POS_W-1:0] j2_lo, j2_hi, j3_lo, j3_hi;
  logic [RATE_W-1:0] rate_hz;
  logic signed [POS_W-1:0] cur_pos[3], start_pos[3], goal_pos[3];
  int unsigned tick_no, tick_count;
  logic [31:0] rate_dur;
  logic cubic_on, in_motion;

  in_item_t pending_items[$];
  out_item_t expected_setpoints[$];
  int errors = 0;
  int cycles = 0;
  int stall_cycles = 0;
  logic in_taken = 1'b0;
  int burst_left = 0, gap_left = 0;
  int ready_run = 0;
  logic ready_steady = 1'b1;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic void reset_model();
    j2_lo = J2_LOW_RESET; j2_hi = J2_HIGH_RESET;
    j3_lo = J3_LOW_RESET; j3_hi = J3_HIGH_RESET;
    rate_hz = RATE_RESET;
    for (int i = 0; i < 3; i++) begin
      cur_pos[i] = '0; start_pos[i] = '0; goal_pos[i] = '0;
    end
    cur_pos[2] = EXT_RESET; start_pos[2] = EXT_RESET; goal_pos[2] = EXT_RESET;
    tick_no = 0; tick_count = 0; rate_dur = '0; cubic_on = 1'b0; in_motion = 1'b0;
  endfunction

  function automatic void write_model_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] v);
    case (idx)
      REG_J2_LOW:    j2_lo = v;
      REG_J2_HIGH:   j2_hi = v;
      REG_J3_LOW:    j3_lo = v;
      REG_J3_HIGH:   j3_hi = v;
      REG_TICK_RATE: rate_hz = v[RATE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void snap_to_goal();
    for (int i = 0; i < 3; i++) cur_pos[i] = goal_pos[i];
    in_motion = 1'b0; tick_no = 0; tick_count = 0;
  endfunction

  function automatic out_item_t advance_setpoints(in_item_t it);
    out_item_t r;
    status_t st;
    longint a1, prod, s, s2, s3, h, d;
    logic [63:0] num, den;
    st = STAT_OK;
    if (it.operation == OP_COMMAND) begin
      a1 = longint'(it.target_angle1);
      if (it.duration == '0) st = STAT_BAD_DUR;
      else if (it.target_angle2 > j2_hi || it.target_angle2 < j2_lo) st = STAT_J2_RANGE;
      else if (it.target_extension > j3_hi || it.target_extension < j3_lo)
        st = STAT_J3_RANGE;
      else begin
        prod = longint'(rate_hz) * longint'(it.duration);
        while (a1 > PI_Q) a1 -= 2 * PI_Q;
        while (a1 < -PI_Q) a1 += 2 * PI_Q;
        goal_pos[0] = a1[POS_W-1:0];
        goal_pos[1] = it.target_angle2;
        goal_pos[2] = it.target_extension;
        for (int i = 0; i < 3; i++) start_pos[i] = cur_pos[i];
        rate_dur = prod[31:0];
        tick_count = int'(prod >> 10);
        tick_no = 1;
        cubic_on = it.cubic_mode;
        in_motion = 1'b1;
        if (tick_count == 0) snap_to_goal();
      end
    end else if (in_motion) begin
      if (tick_no >= tick_count || rate_dur == 0) snap_to_goal();
      else begin
        num = 64'(tick_no) << 41;
        den = 64'(rate_dur);
        s = longint'(num / den);
        if (s > (64'sd1 <<< 31)) s = 64'sd1 <<< 31;
        if (cubic_on) begin
          s2 = (s * s) >>> 31;
          s3 = (s2 * s) >>> 31;
          h = 3 * s2 - 2 * s3;
        end else h = s;
        for (int i = 0; i < 3; i++) begin
          d = (longint'(goal_pos[i]) - longint'(start_pos[i])) * h + (64'sd1 <<< 30);
          d = longint'(start_pos[i]) + (d >>> 31);
          cur_pos[i] = d[POS_W-1:0];
        end
        tick_no++;
      end
    end
    r.angle1 = cur_pos[0];
    r.angle2 = cur_pos[1];
    r.extension = cur_pos[2];
    r.status = st;
    r.moving = in_motion;
    return r;
  endfunction

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (!rst) begin
      in_taken = in_valid && in_ready;
      if (cfg_valid && cfg_ready) write_model_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        expected_setpoints.insert(expected_setpoints.size(), advance_setpoints(in_data));
      if (out_valid && out_ready) begin
        if (expected_setpoints.size() == 0) report("unexpected word", 0, 0);
        else begin
          want = expected_setpoints.pop_front();
          if (out_data.angle1 !== want.angle1) report("angle1", out_data.angle1, want.angle1);
          if (out_data.angle2 !== want.angle2) report("angle2", out_data.angle2, want.angle2);
          if (out_data.extension !== want.extension)
            report("extension", out_data.extension, want.extension);
          if (out_data.status !== want.status) report("status", out_data.status, want.status);
          if (out_data.moving !== want.moving) report("moving", out_data.moving, want.moving);
        end
      end
    end
  end

  // sender: bursts with gaps, payload held until taken
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
        end
      end else in_valid <= 1'b0;
    end
  end

  // receiver: long hold-off on request, else alternating steady and random stalls
  always @(negedge clk) begin
    if (stall_cycles > 0) begin
      stall_cycles--;
      out_ready <= 1'b0;
    end else begin
      if (ready_run == 0) begin
        ready_run = $urandom_range(20, 400);
        ready_steady = $urandom_range(0, 2) == 0;
      end
      ready_run--;
      out_ready <= ready_steady ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [POS_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || expected_setpoints.size() != 0 || in_valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic signed [POS_W-1:0] pick_between(logic signed [POS_W-1:0] lo,
                                                          logic signed [POS_W-1:0] hi);
    if (lo > hi) return POS_W'($urandom);
    return POS_W'(int'(lo) + int'($urandom_range(0, int'(hi) - int'(lo))));
  endfunction

  function automatic void add_item(logic op, int a1, int a2, int e3, int dur, logic cub);
    in_item_t it;
    it.operation = op;
    it.target_angle1 = a1[POS_W-1:0];
    it.target_angle2 = a2[POS_W-1:0];
    it.target_extension = e3[POS_W-1:0];
    it.duration = dur[DUR_W-1:0];
    it.cubic_mode = cub;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void add_ticks(int n);
    repeat (n) add_item(OP_TICK, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
  endfunction

  // mostly well-formed motions followed by their ticks, the rest noise
  task automatic add_random_moves(int items);
    int n, dur, a2, e3;
    while (items > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
        if (rate_hz == 0) dur = $urandom_range(1, 1048575);
        else dur = (n * 1024 + $urandom_range(0, 1023)) / rate_hz;
        if (dur < 1) dur = 1;
        if (dur > 1048575) dur = 1048575;
        a2 = pick_between(j2_lo, j2_hi);
        e3 = pick_between(j3_lo, j3_hi);
        add_item(OP_COMMAND, $urandom, a2, e3, dur, 1'($urandom));
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : n + $urandom_range(0, 2);
        add_ticks(n);
        items -= n + 1;
      end else begin
        add_item(1'($urandom), $urandom, $urandom, $urandom,
                 ($urandom_range(0, 7) == 0) ? 0 : $urandom, 1'($urandom));
        items--;
      end
    end
  endtask

  initial begin
    reset_model();
    rst <= 1'b1;
    in_valid <= 1'b0; in_data <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: rejections, wrap extremes, idle ticks, interrupts, both shapes
    add_ticks(2);
    add_item(OP_COMMAND, 0, 0, 100000, 0, 1'b0);
    add_item(OP_COMMAND, 0, 147863, 100000, 100, 1'b0);
    add_item(OP_COMMAND, 0, -154416, 100000, 100, 1'b0);
    add_item(OP_COMMAND, 0, 0, 196609, 100, 1'b0);
    add_item(OP_COMMAND, 0, 0, -1, 100, 1'b0);
    add_item(OP_COMMAND, 524287, 147862, 196608, 1, 1'b0);
    add_item(OP_COMMAND, -524288, -154415, 0, 1, 1'b1);
    add_item(OP_COMMAND, int'(PI_Q), 0, 0, 1, 1'b0);
    add_item(OP_COMMAND, -int'(PI_Q) - 1, 0, 0, 1, 1'b0);
    add_item(OP_COMMAND, 300000, 100000, 150000, 300, 1'b0);
    add_ticks(7);
    add_item(OP_COMMAND, -300000, -100000, 20000, 1048575, 1'b1);
    add_ticks(3);
    add_item(OP_COMMAND, 100000, 50000, 90000, 250, 1'b1);
    add_ticks(6);
    settle();

    stall_cycles = 600;
    add_random_moves(250);
    settle();

    write_reg(REG_J2_LOW, 20'h80000);
    write_reg(REG_J2_HIGH, 20'h7FFFF);
    write_reg(REG_J3_LOW, 20'h80000);
    write_reg(REG_J3_HIGH, 20'h7FFFF);
    write_reg(REG_TICK_RATE, 20'd1000);
    settle();
    add_item(OP_COMMAND, 524287, -524288, 524287, 1048575, 1'b1);
    add_ticks(3);
    add_item(OP_COMMAND, -524288, 524287, -524288, 1048575, 1'b0);
    add_ticks(3);
    add_random_moves(200);
    settle();

    write_reg(REG_TICK_RATE, 20'd1);
    write_reg(REG_J2_LOW, 20'hF0000);
    write_reg(REG_J2_HIGH, 20'h10000);
    write_reg(REG_J3_LOW, 20'h08000);
    write_reg(REG_J3_HIGH, 20'h28000);
    settle();
    add_random_moves(200);
    settle();

    // rate of zero through the low bits only; unused indexes must be ignored
    write_reg(REG_TICK_RATE, 20'hFFC00);
    write_reg(cfg_reg_t'(5), 20'hFFFFF);
    write_reg(cfg_reg_t'(6), 20'h12345);
    write_reg(cfg_reg_t'(7), 20'h00000);
    settle();
    add_random_moves(40);
    settle();
    write_reg(REG_J2_LOW, 20'h7FFFF);
    write_reg(REG_J2_HIGH, 20'h80000);
    write_reg(REG_TICK_RATE, 20'd37);
    settle();
    add_random_moves(40);
    settle();

    write_reg(REG_J2_LOW, J2_LOW_RESET);
    write_reg(REG_J2_HIGH, J2_HIGH_RESET);
    write_reg(REG_J3_LOW, J3_LOW_RESET);
    write_reg(REG_J3_HIGH, J3_HIGH_RESET);
    write_reg(REG_TICK_RATE, 20'($urandom_range(1, 1023)));
    settle();
    stall_cycles = 400;
    add_random_moves(170);
    settle();

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
